/* design/hcbp_pkg.sv */
package hcbp_pkg;

   // item kinds on the request channel
   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_RAW    = 2'd2,
      REQ_FINISH = 2'd3
   } req_kind_type;

   // field widths fixed by the stream format
   localparam int SYMBOL_W   = 8;
   localparam int LENGTH_W   = 7;
   localparam int CODE_W     = 64;
   localparam int BYTE_W     = 8;
   localparam int RESIDUE_W  = BYTE_W - 1;

   // trailer rule
   localparam int TRAILER_SHORT = 5;
   localparam int TRAILER_LONG  = 13;

   // defaults for the top-level parameters
   localparam int DEF_SYMBOL_COUNT = 256;
   localparam int DEF_MAX_CODE_LEN = 64;

   // table stage to packer
   typedef struct packed {
      logic valid;
      logic finish;
   } pk_ctl_type;

endpackage

/* design/hcbp_code_table.sv */
module hcbp_code_table
   import hcbp_pkg::*;
#(
   parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  req_kind_type                      req_kind,
   input  logic [SYMBOL_W-1:0]               req_symbol,
   input  logic [LENGTH_W-1:0]               req_length,
   input  logic [CODE_W-1:0]                 req_bits,
   output pk_ctl_type                        pk_ctl,
   output logic [MAX_CODE_LEN-1:0]           pk_bits,
   output logic [$clog2(MAX_CODE_LEN+1)-1:0] pk_len,
   input  logic                              pk_ready
);

   localparam int IDX_W = $clog2(SYMBOL_COUNT);
   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
   localparam int MEM_W = MAX_CODE_LEN + LEN_W;

   logic [MEM_W-1:0] table_mem [SYMBOL_COUNT];

   logic                    accept;
   logic                    in_range;
   logic [LEN_W-1:0]        len_clamped;
   logic [IDX_W-1:0]        idx;
   logic                    take;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_finish_ff;
   logic                    s1_raw_ff;
   logic [MAX_CODE_LEN-1:0] s1_bits_ff;
   logic [LEN_W-1:0]        s1_len_ff;
   logic [MEM_W-1:0]        rd_ff;

   assign req_ready   = !s1_valid_ff || pk_ready;
   assign accept      = req_valid && req_ready;
   assign in_range    = {1'b0, req_symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT);
   assign idx         = req_symbol[IDX_W-1:0];
   assign len_clamped = (req_length > LENGTH_W'(MAX_CODE_LEN)) ?
                        LEN_W'(MAX_CODE_LEN) : req_length[LEN_W-1:0];

   always_comb begin
      unique case (req_kind)
         REQ_LOAD:   take = 1'b0;
         REQ_ENCODE: take = in_range;
         REQ_RAW:    take = 1'b1;
         REQ_FINISH: take = 1'b1;
         default:    take = 1'b0;
      endcase
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = take;
      end else if (pk_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // write on load, registered read on encode
   always_ff @(posedge clock) begin
      if (accept && req_kind == REQ_LOAD && in_range) begin
         table_mem[idx] <= {len_clamped, req_bits[MAX_CODE_LEN-1:0]};
      end
      if (accept && req_kind == REQ_ENCODE) begin
         rd_ff <= table_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_finish_ff <= (req_kind == REQ_FINISH);
         s1_raw_ff    <= (req_kind == REQ_RAW);
         s1_bits_ff   <= req_bits[MAX_CODE_LEN-1:0];
         s1_len_ff    <= len_clamped;
      end
   end

   assign pk_ctl.valid  = s1_valid_ff;
   assign pk_ctl.finish = s1_finish_ff;
   assign pk_bits = s1_raw_ff ? s1_bits_ff : rd_ff[MAX_CODE_LEN-1:0];
   assign pk_len  = s1_raw_ff ? s1_len_ff  : rd_ff[MEM_W-1:MAX_CODE_LEN];

endmodule

/* design/hcbp_packer.sv */
module hcbp_packer
   import hcbp_pkg::*;
#(
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pk_ctl_type                        pk_ctl,
   input  logic [MAX_CODE_LEN-1:0]           pk_bits,
   input  logic [$clog2(MAX_CODE_LEN+1)-1:0] pk_len,
   output logic                              pk_ready,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [BYTE_W-1:0]                 out_byte,
   output logic                              out_last,
   output logic                              out_end
);

   localparam int QW    = MAX_CODE_LEN + RESIDUE_W;
   localparam int CW    = $clog2(QW + 1);

   function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = v[BYTE_W-1-i];
      end
      return r;
   endfunction

   // bit queue in stream order, bit 0 leaves first
   logic [QW-1:0]           q_ff, q_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    end_ff, end_in;

   logic                    out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]       out_byte_ff;
   logic                    out_last_ff;
   logic                    out_end_ff;

   logic                    out_free;
   logic                    busy;
   logic                    emit;
   logic                    last_byte;
   logic [QW-1:0]           q_sh;
   logic [CW-1:0]           cnt_sh;
   logic [RESIDUE_W-1:0]    res_q;
   logic [2:0]              res_c;
   logic                    load;
   logic [MAX_CODE_LEN-1:0] mask;
   logic [QW-1:0]           q_code;
   logic [QW-1:0]           q_trail;
   logic [CW-1:0]           cnt_trail;

   assign out_free  = !out_valid_ff || out_ready;
   assign busy      = cnt_ff >= CW'(BYTE_W);
   assign emit      = busy && out_free;
   assign last_byte = cnt_ff < CW'(2 * BYTE_W);
   assign q_sh      = q_ff >> BYTE_W;
   assign cnt_sh    = cnt_ff - CW'(BYTE_W);

   // leftover bits once the current item's bytes are gone
   assign res_q    = busy ? q_sh[RESIDUE_W-1:0] : q_ff[RESIDUE_W-1:0];
   assign res_c    = busy ? cnt_sh[2:0] : cnt_ff[2:0];
   assign pk_ready = !busy || (emit && last_byte);
   assign load     = pk_ctl.valid && pk_ready;

   always_comb begin
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
         mask[i] = i < int'(pk_len);
      end
   end

   assign q_code = (QW'(pk_bits & mask) << res_c) | QW'(res_q);

   // trailer bytes stored bit-reversed so the normal emit path restores them
   always_comb begin
      q_trail = '0;
      q_trail[RESIDUE_W-1:0] = res_q;
      if (res_c <= 3'(TRAILER_SHORT)) begin
         q_trail[BYTE_W-1:0] = {1'b0, res_q} | rev8(BYTE_W'(TRAILER_SHORT) - BYTE_W'(res_c));
         cnt_trail = CW'(BYTE_W);
      end else begin
         q_trail[2*BYTE_W-1:BYTE_W] = rev8(BYTE_W'(TRAILER_LONG) - BYTE_W'(res_c));
         cnt_trail = CW'(2 * BYTE_W);
      end
   end

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      end_in = end_ff;
      if (load) begin
         if (pk_ctl.finish) begin
            q_in   = q_trail;
            cnt_in = cnt_trail;
            end_in = 1'b1;
         end else begin
            q_in   = q_code;
            cnt_in = CW'(pk_len) + CW'(res_c);
            end_in = 1'b0;
         end
      end else if (emit) begin
         q_in   = q_sh;
         cnt_in = cnt_sh;
      end
   end

   assign out_valid_in = out_free ? emit : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff         <= '0;
         cnt_ff       <= '0;
         end_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         q_ff         <= q_in;
         cnt_ff       <= cnt_in;
         end_ff       <= end_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= rev8(q_ff[BYTE_W-1:0]);
         out_last_ff <= last_byte;
         out_end_ff  <= end_ff && last_byte;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;
   assign out_end   = out_end_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(QW))
      else $error("packer bit count out of range");

   a_residue_clean: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (q_ff[QW-1:RESIDUE_W] == '0))
      else $error("stale bits above residue");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_end_ff) |-> out_last_ff)
      else $error("stream end without last");

   a_no_emit_stalled: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> $stable(out_byte_ff))
      else $error("output byte changed under stall");

endmodule

/* design/huffman_code_bit_packer.sv */
// channel  dir  tdata (low bit up)                               tuser       tlast
// req      in   symbol[7:0] code_length[14:8] code_bits[78:15]   req_type    -
// rsp      out  out_byte[7:0]                                     stream_end  last
//
// Load items write the code table in the cycle they are accepted; encode
// items read it through a registered read, and the packer takes them from
// that register. The packer emits one byte per cycle while rsp is ready and
// a whole byte is pending; a finish produces one or two bytes.
// Reset is synchronous and clears the pending bits; the table is not cleared.
// A stalled rsp side holds the output register and backs up into req_tready.
module huffman_code_bit_packer
   import hcbp_pkg::*;
#(
   parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // symbol, code_length, code_bits, zero pad
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser    // stream_end
);

   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

   pk_ctl_type              pk_ctl;
   logic [MAX_CODE_LEN-1:0] pk_bits;
   logic [LEN_W-1:0]        pk_len;
   logic                    pk_ready;
   req_kind_type            req_kind;

   assign req_kind = req_kind_type'(req_tuser);

   // table lookup stage
   hcbp_code_table #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_kind),
      .req_symbol (req_tdata[7:0]),
      .req_length (req_tdata[14:8]),
      .req_bits   (req_tdata[78:15]),
      .pk_ctl     (pk_ctl),
      .pk_bits    (pk_bits),
      .pk_len     (pk_len),
      .pk_ready   (pk_ready)
   );

   // bit queue, trailer and output register
   hcbp_packer #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_packer (
      .clock     (clock),
      .reset     (reset),
      .pk_ctl    (pk_ctl),
      .pk_bits   (pk_bits),
      .pk_len    (pk_len),
      .pk_ready  (pk_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_end   (rsp_tuser)
   );

endmodule

/* tb/sv/huffman_code_bit_packer_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, keeps its own code table and pending byte, and
// compares every rsp item against the oldest predicted byte.
module huffman_code_bit_packer_checker
   import hcbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,   // symbol, code_length, code_bits, zero pad
   input  logic [1:0]  req_tuser,   // req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // out_byte
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,   // stream_end
   output int          error_count,
   output int          outstanding
);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       stream_end;
   } packed_byte_type;

   logic [CODE_W-1:0]   codebook_bits [DEF_SYMBOL_COUNT];
   logic [LENGTH_W-1:0] codebook_len  [DEF_SYMBOL_COUNT];
   logic [7:0]          residue;       // newest bit in bit zero
   int                  residue_cnt;
   packed_byte_type     packed_byte_q [$];

   initial begin
      error_count = 0;
      outstanding = 0;
      residue     = '0;
      residue_cnt = 0;
   end

   function automatic logic [LENGTH_W-1:0] sat_len(input logic [LENGTH_W-1:0] len);
      return (len > DEF_MAX_CODE_LEN) ? LENGTH_W'(DEF_MAX_CODE_LEN) : len;
   endfunction

   // shift len bits, bit zero first; the final byte of the item carries last
   task automatic pack_code_bits(input logic [CODE_W-1:0] bits, input int len);
      int total;
      int k;
      total = (residue_cnt + len) / BYTE_W;
      k     = 0;
      for (int j = 0; j < len; j++) begin
         residue = {residue[6:0], bits[j]};
         residue_cnt++;
         if (residue_cnt == BYTE_W) begin
            k++;
            packed_byte_q.push_back('{residue, k == total, 1'b0});
            residue     = '0;
            residue_cnt = 0;
         end
      end
   endtask

   task automatic emit_trailer();
      logic [7:0] top;
      top = residue << (BYTE_W - residue_cnt);
      if (residue_cnt <= TRAILER_SHORT) begin
         packed_byte_q.push_back('{top | 8'(TRAILER_SHORT - residue_cnt), 1'b1, 1'b1});
      end else begin
         packed_byte_q.push_back('{top, 1'b0, 1'b0});
         packed_byte_q.push_back('{8'(TRAILER_LONG - residue_cnt), 1'b1, 1'b1});
      end
      residue     = '0;
      residue_cnt = 0;
   endtask

   always @(posedge clock) begin
      packed_byte_type want;
      logic [7:0]      sym;
      logic [6:0]      len;
      logic [63:0]     bits;
      if (reset) begin
         residue     = '0;
         residue_cnt = 0;
         packed_byte_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (packed_byte_q.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: unexpected rsp item byte %02h last %0b end %0b",
                           $realtime, rsp_tdata, rsp_tlast, rsp_tuser);
               error_count++;
            end else begin
               want = packed_byte_q.pop_front();
               if (want.data !== rsp_tdata || want.last !== rsp_tlast ||
                   want.stream_end !== rsp_tuser) begin
                  if (error_count < 10)
                     $display("%0t: rsp mismatch, exp %02h/%0b/%0b got %02h/%0b/%0b",
                              $realtime, want.data, want.last, want.stream_end,
                              rsp_tdata, rsp_tlast, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            sym  = req_tdata[7:0];
            len  = sat_len(req_tdata[14:8]);
            bits = req_tdata[78:15];
            case (req_kind_type'(req_tuser))
               REQ_LOAD: begin
                  codebook_bits[sym] = bits;
                  codebook_len[sym]  = len;
               end
               REQ_ENCODE: pack_code_bits(codebook_bits[sym], int'(codebook_len[sym]));
               REQ_RAW:    pack_code_bits(bits, int'(len));
               default:    emit_trailer();
            endcase
         end
      end
      outstanding = packed_byte_q.size();
   end

endmodule

/* tb/sv/huffman_code_bit_packer_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict; all checking lives in the checker instance.
module huffman_code_bit_packer_tb;
   import hcbp_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;    // symbol, code_length, code_bits, zero pad
   logic [1:0]  req_tuser;    // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // out_byte
   logic        rsp_tlast;    // last
   logic        rsp_tuser;    // stream_end

   int          chk_errors;
   int          chk_outstanding;
   int          items_sent;
   logic        calm;         // no idling on either side while set
   logic        hold_done;

   // code table entries written so far; encodes only pick from these
   logic [255:0] loaded;
   logic [7:0]   loaded_syms [$];

   huffman_code_bit_packer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   huffman_code_bit_packer_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .error_count (chk_errors),
      .outstanding (chk_outstanding)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit: far above the slowest legal run (every item 8 bytes, each
   // byte behind a long stall, plus the long hold-off)
   initial begin
      #8_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm)
         return 0;
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // code lengths: Huffman-like short codes mostly, with zero, long
   // and over-range (saturating) lengths mixed in
   function automatic logic [6:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return 7'd0;
      if (r < 70)
         return 7'($urandom_range(1, 12));
      if (r < 85)
         return 7'($urandom_range(13, 40));
      if (r < 93)
         return 7'($urandom_range(41, 64));
      return 7'($urandom_range(65, 127));
   endfunction

   // Called at a falling edge; returns at the falling edge after the item
   // was taken. valid stays high between back-to-back items.
   task automatic send_item(input req_kind_type kind, input logic [7:0] sym,
                            input logic [6:0] len, input logic [63:0] bits);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid        = 1'b0;
         req_tdata[78:15]  = {$urandom(), $urandom()};  // noise while idle
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {1'b0, bits, len, sym};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
      if (kind == REQ_LOAD && !loaded[sym]) begin
         loaded[sym] = 1'b1;
         loaded_syms.push_back(sym);
      end
   endtask

   // sender pause: hold off until every predicted byte has come out
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (chk_outstanding != 0) @(negedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off while the sender keeps
   // offering, so the block backs up into req_tready
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!hold_done && items_sent >= 120) begin
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
            hold_done = 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      int          r;
      logic [7:0]  sym;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_LOAD;
      items_sent = 0;
      calm       = 1'b0;
      loaded     = '0;
      reset      = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: table extremes, saturating and zero lengths, bits above
      // the length, then the trailer for every pending count class
      send_item(REQ_LOAD,   8'd0,   7'd1,   64'h1);
      send_item(REQ_LOAD,   8'd255, 7'd64,  64'hFFFF_FFFF_FFFF_FFFF);
      send_item(REQ_LOAD,   8'd1,   7'd127, 64'hA5C3_0F96_5A3C_F069);
      send_item(REQ_LOAD,   8'd2,   7'd0,   64'hDEAD_BEEF_0123_4567);
      send_item(REQ_LOAD,   8'd3,   7'd5,   64'hFFFF_FFFF_FFFF_FFE0);
      send_item(REQ_ENCODE, 8'd0,   7'd0,   64'h0);
      send_item(REQ_ENCODE, 8'd255, 7'd0,   64'h0);
      send_item(REQ_ENCODE, 8'd1,   7'd0,   64'h0);
      send_item(REQ_ENCODE, 8'd2,   7'd0,   64'h0);
      send_item(REQ_ENCODE, 8'd3,   7'd0,   64'h0);
      send_item(REQ_RAW,    8'd0,   7'd0,   64'hFFFF_FFFF_FFFF_FFFF);
      send_item(REQ_RAW,    8'hFF,  7'd100, 64'h0123_4567_89AB_CDEF);
      send_item(REQ_RAW,    8'd0,   7'd3,   64'h5);
      send_item(REQ_FINISH, 8'd0,   7'd0,   64'h0);
      send_item(REQ_FINISH, 8'd0,   7'd0,   64'h0);   // empty stream
      send_item(REQ_RAW,    8'd0,   7'd6,   64'h2D);
      send_item(REQ_FINISH, 8'd0,   7'd0,   64'h0);   // two trailer bytes
      send_item(REQ_RAW,    8'd0,   7'd7,   64'h7F);
      send_item(REQ_FINISH, 8'd0,   7'd0,   64'h0);
      send_item(REQ_RAW,    8'd0,   7'd5,   64'h1B);
      send_item(REQ_FINISH, 8'd0,   7'd0,   64'h0);   // largest single byte
      wait_drained();

      // random: mostly encode streams closed by a finish, with table
      // reloads and raw header bits in between
      for (int i = 0; i < 380; i++) begin
         calm = (i >= 280 && i < 330);
         if (i == 200) begin
            wait_drained();
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 15) begin
            send_item(REQ_LOAD, 8'($urandom_range(0, 255)), pick_len(),
                      {$urandom(), $urandom()});
         end else if (r < 62) begin
            sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            send_item(REQ_ENCODE, sym, 7'($urandom()), {$urandom(), $urandom()});
         end else if (r < 86) begin
            send_item(REQ_RAW, 8'($urandom()), pick_len(), {$urandom(), $urandom()});
         end else begin
            send_item(REQ_FINISH, 8'($urandom()), 7'($urandom()),
                      {$urandom(), $urandom()});
         end
      end
      req_tvalid = 1'b0;

      // drain, then give the pipeline time to show any stray item
      while (chk_outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (chk_outstanding != 0)
         $display("%0d predicted rsp items never arrived", chk_outstanding);
      if (chk_errors == 0 && chk_outstanding == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* files.f */
design/hcbp_pkg.sv
design/hcbp_code_table.sv
design/hcbp_packer.sv
design/huffman_code_bit_packer.sv
tb/sv/huffman_code_bit_packer_checker.sv
tb/sv/huffman_code_bit_packer_tb.sv
